[hw/rtl/ahdc_pkg.sv]
package ahdc_pkg;

    localparam int BUF_DEPTH = 10;
    localparam int BUF_IDX_W = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;

    localparam logic [4:0] BASE_TEN     = 5'd10;
    localparam logic [4:0] BASE_SIXTEEN = 5'd16;

    localparam logic [1:0] PREFIX_LEN = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       char_last;
    } char_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       out_last;
        logic       error;
    } text_item_t;

    typedef enum logic [1:0] {
        ST_IN,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic clear;
    } acc_ctrl_t;

    typedef struct packed {
        logic start;
        logic base_ten;
    } div_ctrl_t;

    // {valid, value}
    function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
        logic [4:0] res;
        res = 5'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            res = {1'b1, 4'(c - CHAR_ZERO)};
        end
        else if (hex && c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            res = {1'b1, 4'(c - CHAR_UP_A + 8'd10)};
        end
        else if (hex && c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            res = {1'b1, 4'(c - CHAR_LO_A + 8'd10)};
        end
        return res;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] res;
        if (d < 4'd10) begin
            res = CHAR_ZERO + {4'd0, d};
        end
        else begin
            res = CHAR_UP_A + {4'd0, d} - 8'd10;
        end
        return res;
    endfunction

endpackage

[hw/rtl/ahdc_acc.sv]
module ahdc_acc #(
    parameter int ACC_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ahdc_pkg::acc_ctrl_t   ctrl,
    input  logic [7:0]            ch,
    output logic [ACC_BITS-1:0]   value,
    output logic                  hex_mode,
    output logic                  error
);

    localparam int SumW = ACC_BITS + 5;

    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic                hex_reg, hex_next;
    logic [4:0]          pos_reg, pos_next;
    logic                err_reg, err_next;

    logic [4:0]      dig;
    logic            prefix;
    logic [SumW-1:0] acc_ext;
    logic [SumW-1:0] scaled;
    logic [SumW-1:0] sum;
    logic            over;

    assign dig     = ahdc_pkg::digit_value(ch, hex_reg);
    assign prefix  = (pos_reg == 5'd1) && !hex_reg && !err_reg && (acc_reg == '0) &&
                     ((ch == ahdc_pkg::CHAR_LO_X) || (ch == ahdc_pkg::CHAR_UP_X));
    assign acc_ext = SumW'(acc_reg);
    assign scaled  = hex_reg ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
    assign sum     = scaled + SumW'(dig[3:0]);
    assign over    = |sum[SumW-1:ACC_BITS];

    always_comb
    begin
        acc_next = acc_reg;
        hex_next = hex_reg;
        pos_next = pos_reg;
        err_next = err_reg;
        if (ctrl.clear) begin
            acc_next = '0;
            hex_next = 1'b0;
            pos_next = 5'd0;
            err_next = 1'b0;
        end
        else if (ctrl.take) begin
            if (prefix) begin
                hex_next = 1'b1;
            end
            else if (!dig[4]) begin
                err_next = 1'b1;
            end
            else if (over) begin
                err_next = 1'b1;
                acc_next = '1;
            end
            else begin
                acc_next = sum[ACC_BITS-1:0];
            end
            if (pos_reg != 5'd31) begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= '0;
            hex_reg <= 1'b0;
            pos_reg <= 5'd0;
            err_reg <= 1'b0;
        end
        else begin
            acc_reg <= acc_next;
            hex_reg <= hex_next;
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    assign value    = acc_reg;
    assign hex_mode = hex_reg;
    assign error    = err_reg;

endmodule

[hw/rtl/ahdc_div.sv]
module ahdc_div #(
    parameter int ACC_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ahdc_pkg::div_ctrl_t   ctrl,
    input  logic [ACC_BITS-1:0]   dividend,
    output logic [ACC_BITS-1:0]   quot,
    output logic [3:0]            rem,
    output logic                  done
);

    localparam logic [31:0] TenMagic  = 32'hCCCCCCCD;
    localparam logic [1:0]  PhaseIdle = 2'd0;
    localparam logic [1:0]  PhaseRem  = 2'd1;
    localparam logic [1:0]  PhaseQuot = 2'd2;

    logic [ACC_BITS-1:0] num_reg, num_next;
    logic [ACC_BITS-1:0] quot_reg, quot_next;
    logic [3:0]          rem_reg, rem_next;
    logic [1:0]          phase_reg, phase_next;
    logic                done_reg, done_next;
    logic                ten_reg, ten_next;

    logic [63:0] prod;
    logic [31:0] quot_ten;
    logic [3:0]  ten_low;

    // floor(n / 10) = (n * 0xCCCCCCCD) >> 35 for any 32-bit n
    assign prod     = 64'(num_reg) * 64'(TenMagic);
    assign quot_ten = {3'd0, prod[63:35]};
    assign ten_low  = {quot_reg[0], 3'd0} + {quot_reg[2:0], 1'b0};

    always_comb
    begin
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        ten_next   = ten_reg;
        done_next  = 1'b0;
        if (ctrl.start) begin
            num_next   = dividend;
            ten_next   = ctrl.base_ten;
            phase_next = PhaseQuot;
        end
        else if (phase_reg == PhaseQuot) begin
            quot_next  = ten_reg ? quot_ten[ACC_BITS-1:0] : (num_reg >> 4);
            phase_next = PhaseRem;
        end
        else if (phase_reg == PhaseRem) begin
            rem_next   = ten_reg ? (num_reg[3:0] - ten_low) : num_reg[3:0];
            phase_next = PhaseIdle;
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PhaseIdle;
            done_reg  <= 1'b0;
        end
        else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        ten_reg  <= ten_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

[hw/rtl/ascii_hex_decimal_converter_unit.sv]
// ASCII hexadecimal / decimal converter.
// Input channel (char_valid, char_stall, char_data): one ASCII character per
// transfer, char_last set on the final character of a token. A token starting
// "0x" or "0X" is hexadecimal, any other token decimal.
// Output channel (text_valid, text_stall, text_data): the converted text, one
// character per transfer, out_last on its final character, error on every
// character of a token with a bad digit or an accumulator overflow.
// The block keeps char_stall low while it waits for and reads a token.
// After the last character the block stalls the input through a load state,
// then for each output digit a shared divide-by-base unit (a reciprocal
// multiply for ten, a shift for sixteen) forms the quotient and then the
// remainder; the block then sends the result characters (up to ten).
// A stall on the output holds the result register; the sequencer waits.
// The output register frees the input side as soon as the last result is loaded.
// Reset clears the accumulator, the sequencer and the output valid.
module ascii_hex_decimal_converter_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  ahdc_pkg::char_item_t    char_data,
    output logic                    text_valid,
    input  logic                    text_stall,
    output ahdc_pkg::text_item_t    text_data
);

    localparam int AccBits = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int IdxW    = ahdc_pkg::BUF_IDX_W;
    localparam int Depth   = ahdc_pkg::BUF_DEPTH;

    ahdc_pkg::state_t state_reg, state_next;

    logic                tok_hex_reg, tok_hex_next;
    logic                tok_err_reg, tok_err_next;
    logic [IdxW-1:0]     n_reg, n_next;
    logic [IdxW-1:0]     dig_reg, dig_next;
    logic [1:0]          pfx_reg, pfx_next;
    logic [3:0]          buf_reg [Depth];
    logic [3:0]          buf_next [Depth];
    logic                out_valid_reg, out_valid_next;
    ahdc_pkg::text_item_t out_data_reg, out_data_next;

    ahdc_pkg::acc_ctrl_t acc_ctrl;
    ahdc_pkg::div_ctrl_t div_ctrl;
    logic [AccBits-1:0]  acc_value;
    logic                acc_hex;
    logic                acc_err;
    logic [AccBits-1:0]  div_value;
    logic [AccBits-1:0]  div_quot;
    logic [3:0]          div_rem;
    logic                div_done;
    logic                div_final;
    logic                emit_load;
    logic                emit_last;

    ahdc_acc #(
        .ACC_BITS (AccBits)
    ) u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (acc_ctrl),
        .ch       (char_data.char_in),
        .value    (acc_value),
        .hex_mode (acc_hex),
        .error    (acc_err)
    );

    ahdc_div #(
        .ACC_BITS (AccBits)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_value),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    assign div_final = (div_quot == '0) || (n_reg == IdxW'(Depth - 1));
    assign emit_last = (pfx_reg == 2'd0) && (dig_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ahdc_pkg::ST_IN:
            begin
                if (char_valid && char_data.char_last) begin
                    state_next = ahdc_pkg::ST_LOAD;
                end
            end
            ahdc_pkg::ST_LOAD:
            begin
                state_next = ahdc_pkg::ST_DIV;
            end
            ahdc_pkg::ST_DIV:
            begin
                if (div_done && div_final) begin
                    state_next = ahdc_pkg::ST_EMIT;
                end
            end
            ahdc_pkg::ST_EMIT:
            begin
                if (emit_load && emit_last) begin
                    state_next = ahdc_pkg::ST_IN;
                end
            end
            default:
            begin
                state_next = ahdc_pkg::ST_IN;
            end
        endcase
    end

    always_comb
    begin
        char_stall        = 1'b1;
        acc_ctrl          = '0;
        div_ctrl          = '0;
        div_value         = div_quot;
        emit_load         = 1'b0;
        div_ctrl.base_ten = tok_hex_reg;
        unique case (state_reg)
            ahdc_pkg::ST_IN:
            begin
                char_stall    = 1'b0;
                acc_ctrl.take = char_valid;
            end
            ahdc_pkg::ST_LOAD:
            begin
                acc_ctrl.clear    = 1'b1;
                div_ctrl.start    = 1'b1;
                div_ctrl.base_ten = acc_hex;
                div_value         = acc_value;
            end
            ahdc_pkg::ST_DIV:
            begin
                div_ctrl.start = div_done && !div_final;
            end
            ahdc_pkg::ST_EMIT:
            begin
                emit_load = !out_valid_reg || !text_stall;
            end
            default:
            begin
                char_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        tok_hex_next   = tok_hex_reg;
        tok_err_next   = tok_err_reg;
        n_next         = n_reg;
        dig_next       = dig_reg;
        pfx_next       = pfx_reg;
        buf_next       = buf_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && text_stall;

        if (state_reg == ahdc_pkg::ST_LOAD) begin
            tok_hex_next = acc_hex;
            tok_err_next = acc_err;
            n_next       = '0;
        end

        if (state_reg == ahdc_pkg::ST_DIV && div_done) begin
            buf_next[n_reg] = div_rem;
            n_next          = n_reg + IdxW'(1);
            if (div_final) begin
                dig_next = n_reg;
                pfx_next = tok_hex_reg ? 2'd0 : ahdc_pkg::PREFIX_LEN;
            end
        end

        if (emit_load) begin
            out_valid_next         = 1'b1;
            out_data_next.error    = tok_err_reg;
            out_data_next.out_last = emit_last;
            if (pfx_reg == ahdc_pkg::PREFIX_LEN) begin
                out_data_next.char_out = ahdc_pkg::CHAR_ZERO;
                pfx_next               = pfx_reg - 2'd1;
            end
            else if (pfx_reg != 2'd0) begin
                out_data_next.char_out = ahdc_pkg::CHAR_LO_X;
                pfx_next               = pfx_reg - 2'd1;
            end
            else begin
                out_data_next.char_out = ahdc_pkg::digit_char(buf_reg[dig_reg]);
                if (dig_reg != '0) begin
                    dig_next = dig_reg - IdxW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ahdc_pkg::ST_IN;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            dig_reg       <= '0;
            pfx_reg       <= 2'd0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            dig_reg       <= dig_next;
            pfx_reg       <= pfx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_hex_reg  <= tok_hex_next;
        tok_err_reg  <= tok_err_next;
        buf_reg      <= buf_next;
        out_data_reg <= out_data_next;
    end

    assign text_valid = out_valid_reg;
    assign text_data  = out_data_reg;

endmodule
